// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of i_clk while reset is released.
`define FFHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property at every rising edge of i_clk, reset included.
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/ffha_pkg.sv -----
package ffha_pkg;

    localparam int MaxParts    = 4096;
    localparam int HeaderBytes = 16;
    localparam int HeapBytes   = 65536;
    localparam int HeapMin     = 64;

    localparam int SlotW  = $clog2(MaxParts);
    localparam int CountW = $clog2(MaxParts + 1);
    localparam int BytesW = 16;
    localparam int TotalW = 17;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_BAD_OFFS = 2'd2,
        ST_NO_HEAP  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SPLIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              taken;
        logic [SlotW-1:0]  link;
        logic [BytesW-1:0] bytes;
    } t_entry;

endpackage

// ----- rtl/core/first_fit_heap_allocator.sv -----
// First-fit heap allocator.
// Input channel: i_in_valid / o_in_stall carry one operation per beat
// (allocate, release, initialize). Output channel: o_out_valid / i_out_stall
// carry one result beat per operation: status, payload offset and the
// partition statistics after the operation.
// The partition table lives in one synchronous RAM of 4096 entries. An
// allocate or release walks the list from slot 0, one partition per cycle,
// because each step needs the link read from the RAM in the previous cycle.
// Initialize and rejected operations go via FIN to the output register; a
// walk goes via EVAL once per partition visited and SPLIT when a hole is
// split off, then FIN. One operation is in flight at a time; a new one is
// taken when the previous result sits in the output register. The heap
// size register is written with i_cfg_wr_en / i_cfg_wr_data and is used
// by the next initialize; the user must write it only while the block is
// idle, which it does not enforce. Reset (synchronous, i_rst_n low) marks
// the heap as not initialized and clears the statistics; the RAM is not
// cleared. While i_out_stall is high the result beat holds and at most one
// more operation is taken and finished, after which o_in_stall stays high.
module first_fit_heap_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ffha_pkg::TotalW-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [15:0]                   i_request_bytes,
    input  logic [15:0]                   i_target_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [15:0]                   o_payload_offset,
    output logic [ffha_pkg::CountW-1:0]   o_occupied_parts,
    output logic [ffha_pkg::TotalW-1:0]   o_occupied_bytes,
    output logic [ffha_pkg::CountW-1:0]   o_hole_parts,
    output logic [ffha_pkg::TotalW-1:0]   o_hole_bytes
);

    localparam int SW = ffha_pkg::SlotW;
    localparam int CW = ffha_pkg::CountW;
    localparam int TW = ffha_pkg::TotalW;
    localparam int BW = ffha_pkg::BytesW;
    localparam logic [TW-1:0] Hdr     = TW'(ffha_pkg::HeaderBytes);
    localparam logic [TW-1:0] HdrPlus = TW'(ffha_pkg::HeaderBytes + 4);
    localparam logic [TW:0]   HeapMax = (TW+1)'(ffha_pkg::HeapBytes);
    localparam logic [TW:0]   HeapLo  = (TW+1)'((ffha_pkg::HeapMin > ffha_pkg::HeaderBytes + 4)
                                        ? ffha_pkg::HeapMin : ffha_pkg::HeaderBytes + 4);
    localparam logic [CW-1:0] MaxCnt  = CW'(ffha_pkg::MaxParts);

    ffha_pkg::t_entry r_mem [ffha_pkg::MaxParts];
    ffha_pkg::t_entry r_rdata;

    ffha_pkg::t_state r_state, n_state;
    logic [TW-1:0]    r_heap_size;
    logic [CW-1:0]    r_slots_used, n_slots_used;
    logic [CW-1:0]    r_taken_count, n_taken_count;
    logic [TW-1:0]    r_taken_total, n_taken_total;
    logic [CW-1:0]    r_hole_count, n_hole_count;
    logic [TW-1:0]    r_hole_total, n_hole_total;

    logic [SW-1:0]    r_slot, n_slot;
    logic [CW-1:0]    r_visit, n_visit;
    logic [TW-1:0]    r_off, n_off;
    logic [TW-1:0]    r_need, n_need;
    logic             r_is_alloc, n_is_alloc;
    logic [15:0]      r_tgt, n_tgt;
    ffha_pkg::t_status r_status, n_status;
    logic [15:0]      r_payload, n_payload;
    logic [SW-1:0]    r_new_slot, n_new_slot;
    ffha_pkg::t_entry r_split_entry, n_split_entry;

    logic             r_out_valid;
    logic [1:0]       r_o_status;
    logic [15:0]      r_o_payload;
    logic [CW-1:0]    r_o_tc, r_o_hc;
    logic [TW-1:0]    r_o_tt, r_o_ht;

    logic             rd_en, wr_en;
    logic [SW-1:0]    rd_addr, wr_addr;
    ffha_pkg::t_entry wr_data;

    logic             in_acc, out_free;
    logic [TW:0]      heap_clamp;
    logic [TW-1:0]    req_need;
    logic [TW-1:0]    cur_bytes;
    logic             alloc_hit, rel_hit, split_ok, last_visit;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ffha_pkg::S_IDLE);

    always_comb begin
        heap_clamp = {1'b0, r_heap_size};
        if (heap_clamp > HeapMax) begin
            heap_clamp = HeapMax;
        end
        if (heap_clamp < HeapLo) begin
            heap_clamp = HeapLo;
        end
    end

    assign req_need  = (i_request_bytes == 16'd0) ? TW'(4)
                     : ((TW'(i_request_bytes) + TW'(3)) & ~TW'(3));
    assign cur_bytes = TW'(r_rdata.bytes);
    assign alloc_hit = !r_rdata.taken && (cur_bytes >= r_need);
    assign rel_hit   = ((r_off + Hdr) == TW'(r_tgt));
    assign split_ok  = (cur_bytes >= (r_need + HdrPlus)) && (r_slots_used < MaxCnt);
    assign last_visit = ((r_visit + CW'(1)) == r_slots_used);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_op == ffha_pkg::OP_INIT || i_op == ffha_pkg::OP_NONE
                        || r_slots_used == '0) begin
                        n_state = ffha_pkg::S_FIN;
                    end else begin
                        n_state = ffha_pkg::S_EVAL;
                    end
                end
            end
            ffha_pkg::S_EVAL: begin
                if (r_is_alloc && alloc_hit) begin
                    n_state = split_ok ? ffha_pkg::S_SPLIT : ffha_pkg::S_FIN;
                end else if ((!r_is_alloc && rel_hit) || last_visit) begin
                    n_state = ffha_pkg::S_FIN;
                end
            end
            ffha_pkg::S_SPLIT: begin
                n_state = ffha_pkg::S_FIN;
            end
            ffha_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_slots_used  = r_slots_used;
        n_taken_count = r_taken_count;
        n_taken_total = r_taken_total;
        n_hole_count  = r_hole_count;
        n_hole_total  = r_hole_total;
        n_slot        = r_slot;
        n_visit       = r_visit;
        n_off         = r_off;
        n_need        = r_need;
        n_is_alloc    = r_is_alloc;
        n_tgt         = r_tgt;
        n_status      = r_status;
        n_payload     = r_payload;
        n_new_slot    = r_new_slot;
        n_split_entry = r_split_entry;
        rd_en   = 1'b0;
        rd_addr = r_slot;
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = r_rdata;
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_status   = ffha_pkg::ST_DONE;
                    n_payload  = '0;
                    n_need     = req_need;
                    n_tgt      = i_target_offset;
                    n_is_alloc = (i_op == ffha_pkg::OP_ALLOC);
                    n_slot     = '0;
                    n_visit    = '0;
                    n_off      = '0;
                    if (i_op == ffha_pkg::OP_INIT) begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data.taken = 1'b0;
                        wr_data.link  = '0;
                        wr_data.bytes = BW'(heap_clamp - {1'b0, Hdr});
                        n_slots_used  = CW'(1);
                        n_taken_count = '0;
                        n_taken_total = '0;
                        n_hole_count  = CW'(1);
                        n_hole_total  = TW'(heap_clamp - {1'b0, Hdr});
                    end else if (i_op != ffha_pkg::OP_NONE) begin
                        if (r_slots_used == '0) begin
                            n_status = ffha_pkg::ST_NO_HEAP;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                        end
                    end
                end
            end
            ffha_pkg::S_EVAL: begin
                if (r_is_alloc && alloc_hit) begin
                    n_payload = 16'(r_off + Hdr);
                    wr_en     = 1'b1;
                    wr_addr   = r_slot;
                    wr_data.taken = 1'b1;
                    n_taken_count = r_taken_count + CW'(1);
                    if (split_ok) begin
                        wr_data.link  = r_slots_used[SW-1:0];
                        wr_data.bytes = r_need[BW-1:0];
                        n_new_slot    = r_slots_used[SW-1:0];
                        n_split_entry.taken = 1'b0;
                        n_split_entry.link  = r_rdata.link;
                        n_split_entry.bytes = BW'(cur_bytes - Hdr - r_need);
                        n_slots_used  = r_slots_used + CW'(1);
                        n_hole_total  = r_hole_total - r_need - Hdr;
                        n_taken_total = r_taken_total + r_need;
                    end else begin
                        n_hole_count  = r_hole_count - CW'(1);
                        n_hole_total  = r_hole_total - cur_bytes;
                        n_taken_total = r_taken_total + cur_bytes;
                    end
                end else if (!r_is_alloc && rel_hit) begin
                    if (!r_rdata.taken) begin
                        n_status = ffha_pkg::ST_BAD_OFFS;
                    end else begin
                        wr_en         = 1'b1;
                        wr_addr       = r_slot;
                        wr_data.taken = 1'b0;
                        n_taken_count = r_taken_count - CW'(1);
                        n_taken_total = r_taken_total - cur_bytes;
                        n_hole_count  = r_hole_count + CW'(1);
                        n_hole_total  = r_hole_total + cur_bytes;
                    end
                end else if (last_visit) begin
                    n_status = r_is_alloc ? ffha_pkg::ST_NO_FIT : ffha_pkg::ST_BAD_OFFS;
                end else begin
                    n_visit = r_visit + CW'(1);
                    n_off   = r_off + Hdr + cur_bytes;
                    n_slot  = r_rdata.link;
                    rd_en   = 1'b1;
                    rd_addr = r_rdata.link;
                end
            end
            ffha_pkg::S_SPLIT: begin
                wr_en   = 1'b1;
                wr_addr = r_new_slot;
                wr_data = r_split_entry;
            end
            ffha_pkg::S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ffha_pkg::S_IDLE;
            r_heap_size   <= TW'(ffha_pkg::HeapBytes);
            r_slots_used  <= '0;
            r_taken_count <= '0;
            r_taken_total <= '0;
            r_hole_count  <= '0;
            r_hole_total  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_slots_used  <= n_slots_used;
            r_taken_count <= n_taken_count;
            r_taken_total <= n_taken_total;
            r_hole_count  <= n_hole_count;
            r_hole_total  <= n_hole_total;
            if (i_cfg_wr_en) begin
                r_heap_size <= i_cfg_wr_data;
            end
            if (r_state == ffha_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot        <= n_slot;
        r_visit       <= n_visit;
        r_off         <= n_off;
        r_need        <= n_need;
        r_is_alloc    <= n_is_alloc;
        r_tgt         <= n_tgt;
        r_status      <= n_status;
        r_payload     <= n_payload;
        r_new_slot    <= n_new_slot;
        r_split_entry <= n_split_entry;
        if (r_state == ffha_pkg::S_FIN && out_free) begin
            r_o_status  <= r_status;
            r_o_payload <= r_payload;
            r_o_tc      <= r_taken_count;
            r_o_tt      <= r_taken_total;
            r_o_hc      <= r_hole_count;
            r_o_ht      <= r_hole_total;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_payload_offset = r_o_payload;
    assign o_occupied_parts = r_o_tc;
    assign o_occupied_bytes = r_o_tt;
    assign o_hole_parts     = r_o_hc;
    assign o_hole_bytes     = r_o_ht;

`include "assert_macros.svh"

    `FFHA_ASSERT(a_part_count, ((r_taken_count + r_hole_count) == r_slots_used),
                 "partition counts disagree with slots in use")
    `FFHA_ASSERT(a_slot_limit, (r_slots_used <= MaxCnt), "slot count beyond table size")
    `FFHA_ASSERT(a_split_after_eval,
                 (r_state == ffha_pkg::S_SPLIT |-> $past(r_state) == ffha_pkg::S_EVAL),
                 "split without a preceding hit")
    `FFHA_ASSERT(a_walk_bound, (r_state == ffha_pkg::S_EVAL |-> r_visit < r_slots_used),
                 "walk ran past the list end")

endmodule

// ----- tb/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

    typedef struct packed {
        logic [1:0]                  status;
        logic [15:0]                 payload;
        logic [ffha_pkg::CountW-1:0] occ_parts;
        logic [ffha_pkg::TotalW-1:0] occ_bytes;
        logic [ffha_pkg::CountW-1:0] hole_parts;
        logic [ffha_pkg::TotalW-1:0] hole_bytes;
    } t_result;

    class heap_scoreboard;
        int unsigned part_len [ffha_pkg::MaxParts];
        bit          part_busy [ffha_pkg::MaxParts];
        int unsigned part_next [ffha_pkg::MaxParts];
        int unsigned slot_cnt;
        int unsigned busy_cnt, busy_sum, free_cnt, free_sum;
        int unsigned heap_cfg;
        t_result     pending [$];
        int unsigned errors, checked;

        function void clear();
            slot_cnt = 0; busy_cnt = 0; busy_sum = 0; free_cnt = 0; free_sum = 0;
            heap_cfg = 65536; errors = 0; checked = 0;
        endfunction

        function void set_heap(int unsigned v);
            heap_cfg = v & 32'h1FFFF;
        endfunction

        function void note_op(ffha_pkg::t_op op, int unsigned req, int unsigned tgt);
            t_result r;
            int unsigned st, pay, need, s, off, h, i, n, old;
            bit hit;
            st = ffha_pkg::ST_DONE; pay = 0;
            if (op == ffha_pkg::OP_INIT) begin
                h = heap_cfg;
                if (h > ffha_pkg::HeapBytes) h = ffha_pkg::HeapBytes;
                if (h < ffha_pkg::HeapMin) h = ffha_pkg::HeapMin;
                part_len[0] = h - ffha_pkg::HeaderBytes; part_busy[0] = 0; part_next[0] = 0;
                slot_cnt = 1; busy_cnt = 0; busy_sum = 0;
                free_cnt = 1; free_sum = part_len[0];
            end else if (op == ffha_pkg::OP_ALLOC || op == ffha_pkg::OP_RELEASE) begin
                if (slot_cnt == 0) begin
                    st = ffha_pkg::ST_NO_HEAP;
                end else if (op == ffha_pkg::OP_ALLOC) begin
                    need = (req == 0) ? 4 : ((req + 3) & ~32'd3);
                    s = 0; off = 0; hit = 0; st = ffha_pkg::ST_NO_FIT;
                    for (i = 0; i < slot_cnt && !hit; i++) begin
                        if (!part_busy[s] && part_len[s] >= need) begin
                            hit = 1; old = part_len[s];
                            free_cnt--; free_sum -= old;
                            if (old >= need + ffha_pkg::HeaderBytes + 4
                                && slot_cnt < ffha_pkg::MaxParts) begin
                                n = slot_cnt++;
                                part_len[n] = old - ffha_pkg::HeaderBytes - need;
                                part_busy[n] = 0;
                                part_next[n] = part_next[s];
                                part_next[s] = n;
                                part_len[s] = need;
                                free_cnt++; free_sum += part_len[n];
                            end
                            part_busy[s] = 1; busy_cnt++; busy_sum += part_len[s];
                            pay = off + ffha_pkg::HeaderBytes; st = ffha_pkg::ST_DONE;
                        end else begin
                            off += ffha_pkg::HeaderBytes + part_len[s];
                            s = part_next[s];
                        end
                    end
                end else begin
                    s = 0; off = 0; hit = 0; st = ffha_pkg::ST_BAD_OFFS;
                    for (i = 0; i < slot_cnt && !hit; i++) begin
                        if (off + ffha_pkg::HeaderBytes == tgt) begin
                            hit = 1;
                            if (part_busy[s]) begin
                                part_busy[s] = 0; busy_cnt--; busy_sum -= part_len[s];
                                free_cnt++; free_sum += part_len[s];
                                st = ffha_pkg::ST_DONE;
                            end
                        end else begin
                            off += ffha_pkg::HeaderBytes + part_len[s];
                            s = part_next[s];
                        end
                    end
                end
            end
            r.status = 2'(st); r.payload = 16'(pay);
            r.occ_parts = ffha_pkg::CountW'(busy_cnt);
            r.occ_bytes = ffha_pkg::TotalW'(busy_sum);
            r.hole_parts = ffha_pkg::CountW'(free_cnt);
            r.hole_bytes = ffha_pkg::TotalW'(free_sum);
            pending.push_back(r);
        endfunction

        function void check_beat(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got !== w) begin
                $display("%0t: mismatch expected %p actual %p", $time, w, got);
                errors++;
            end
        endfunction

        function int unsigned busy_offset(int unsigned pick);
            int unsigned s, off, i, k;
            s = 0; off = 0; k = 0;
            for (i = 0; i < slot_cnt; i++) begin
                if (part_busy[s]) begin
                    if (k == pick) return off + ffha_pkg::HeaderBytes;
                    k++;
                end
                off += ffha_pkg::HeaderBytes + part_len[s];
                s = part_next[s];
            end
            return off + ffha_pkg::HeaderBytes;
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_wr_en, i_in_valid, i_out_stall;
    logic [ffha_pkg::TotalW-1:0] i_cfg_wr_data;
    logic [1:0] i_op;
    logic [15:0] i_request_bytes, i_target_offset;
    logic o_in_stall, o_out_valid;
    logic [1:0] o_status;
    logic [15:0] o_payload_offset;
    logic [ffha_pkg::CountW-1:0] o_occupied_parts, o_hole_parts;
    logic [ffha_pkg::TotalW-1:0] o_occupied_bytes, o_hole_bytes;

    first_fit_heap_allocator DUT (.*);

    heap_scoreboard board;
    int unsigned cycle_cnt;
    int unsigned hold_off;
    bit sink_quiet;
    int unsigned sent;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3000000) begin
            $display("first_fit_heap_allocator regression: fail");
            $finish;
        end
    end

    function int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_beat({o_status, o_payload_offset, o_occupied_parts,
                              o_occupied_bytes, o_hole_parts, o_hole_bytes});
    end

    initial begin
        int unsigned g;
        i_out_stall = 1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_out_stall <= 1;
                hold_off = hold_off - 1;
            end else if (sink_quiet) begin
                i_out_stall <= 0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    i_out_stall <= 1;
                    repeat (g - 1) @(negedge i_clk);
                end else begin
                    i_out_stall <= 0;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_op(ffha_pkg::t_op op, int unsigned req, int unsigned tgt, bit quiet);
        int unsigned g;
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_op <= op;
        i_request_bytes <= req[15:0];
        i_target_offset <= tgt[15:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_op(op, req & 32'hFFFF, tgt & 32'hFFFF);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8200) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_heap(int unsigned v);
        drain();
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v[ffha_pkg::TotalW-1:0];
        board.set_heap(v);
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
    endtask

    task automatic random_op();
        int unsigned r, req;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            req = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 300);
            send_op(ffha_pkg::OP_ALLOC, req, $urandom_range(0, 65535), 0);
        end else if (r < 85 && board.busy_cnt > 0) begin
            send_op(ffha_pkg::OP_RELEASE, 0,
                    board.busy_offset($urandom_range(0, board.busy_cnt - 1)), 0);
        end else if (r < 93) begin
            send_op(ffha_pkg::OP_RELEASE, $urandom_range(0, 65535),
                    $urandom_range(0, 65535), 0);
        end else if (r < 97) begin
            send_op(ffha_pkg::OP_NONE, $urandom_range(0, 65535),
                    $urandom_range(0, 65535), 0);
        end else begin
            send_op(ffha_pkg::OP_INIT, $urandom_range(0, 65535),
                    $urandom_range(0, 65535), 0);
        end
    endtask

    initial begin
        int unsigned k, phase;
        int unsigned sizes [5];
        board = new();
        board.clear();
        cycle_cnt = 0; hold_off = 0; sink_quiet = 0; sent = 0;
        i_rst_n = 0; i_cfg_wr_en = 0; i_cfg_wr_data = 0; i_in_valid = 0;
        i_op = ffha_pkg::OP_NONE; i_request_bytes = 0; i_target_offset = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_op(ffha_pkg::OP_ALLOC, 8, 0, 0);
        send_op(ffha_pkg::OP_RELEASE, 0, 16, 0);
        send_op(ffha_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 0);
        write_heap(0);
        send_op(ffha_pkg::OP_INIT, 0, 0, 0);
        send_op(ffha_pkg::OP_ALLOC, 0, 0, 0);
        send_op(ffha_pkg::OP_ALLOC, 13, 0, 0);
        send_op(ffha_pkg::OP_ALLOC, 65535, 0, 0);
        send_op(ffha_pkg::OP_ALLOC, 20, 0, 0);
        send_op(ffha_pkg::OP_RELEASE, 0, 16, 0);
        send_op(ffha_pkg::OP_RELEASE, 0, 16, 0);
        send_op(ffha_pkg::OP_RELEASE, 0, 17, 0);
        send_op(ffha_pkg::OP_RELEASE, 0, 65535, 0);
        send_op(ffha_pkg::OP_ALLOC, 4, 0, 0);
        write_heap(131071);
        send_op(ffha_pkg::OP_INIT, 0, 0, 0);
        send_op(ffha_pkg::OP_ALLOC, 65535, 0, 0);
        send_op(ffha_pkg::OP_ALLOC, 65504, 0, 0);
        send_op(ffha_pkg::OP_RELEASE, 0, 16, 0);
        send_op(ffha_pkg::OP_ALLOC, 65536 - 32, 0, 0);
        send_op(ffha_pkg::OP_RELEASE, 0, 0, 0);
        send_op(ffha_pkg::OP_INIT, 0, 0, 0);

        sink_quiet = 1;
        hold_off = 400;
        for (k = 0; k < 6; k++) send_op(ffha_pkg::OP_ALLOC, $urandom_range(0, 64), 0, 1);
        while (hold_off > 0) @(posedge i_clk);
        sink_quiet = 0;

        sizes[0] = 65536; sizes[1] = 64; sizes[2] = 300;
        sizes[3] = 2048; sizes[4] = 40000;
        for (phase = 0; phase < 5; phase++) begin
            write_heap(sizes[phase]);
            send_op(ffha_pkg::OP_INIT, 0, 0, 0);
            for (k = 0; k < 135; k++) random_op();
        end
        drain();
        $display("Ran %0d operations across 7 heap sizes, %0d result beats checked.",
                 sent, board.checked);
        if (board.errors == 0)
            $display("first_fit_heap_allocator regression: pass");
        else
            $display("first_fit_heap_allocator regression: fail");
        $finish;
    end
endmodule
